// ===== sv/bsc_pkg.sv =====
// Shared widths, reset values, register indexes and interface structs of the centroid block.
package bsc_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int SUM_W     = 36;
  localparam int TOT_W     = 25;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [PIX_W-1:0] THR_RESET = 8'd100;
  localparam logic [CFG_W-1:0] FW_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FH_RESET  = 13'd480;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [TOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // Accumulator status: frame end flag and totals including the current pixel
  typedef struct packed {
    logic             frame_end;
    logic [TOT_W-1:0] total;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } acc_stat_t;

endpackage

// ===== sv/bright_spot_centroid_core.sv =====
// The frame result is registered: it is valid in the cycle after the last pixel when no
// pixel is bright, otherwise after two 36-step divisions, column then row, each with a
// load, and then the output register.
// Throughput: one pixel per cycle within a frame; after the last pixel the input is held
// off while the shared bit-serial divider runs; a last pixel waits while a result is untaken.
// Reset (rst_n, synchronous, active low) clears counters, sums and handshakes and loads
// threshold 100, width 640, height 480.
module bright_spot_centroid_core #(
  parameter int MAX_WIDTH  = bsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // red, green, blue
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // center_x, center_y
  output logic                              out_tuser,  // none_found
  input  logic                              cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

  state_t state_r;

  logic [bsc_pkg::PIX_W-1:0] thr_r;
  logic [bsc_pkg::CFG_W-1:0] fw_r;
  logic [bsc_pkg::CFG_W-1:0] fh_r;

  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  bsc_pkg::acc_stat_t acc_st;
  bsc_pkg::div_req_t  div_req;
  bsc_pkg::div_rsp_t  div_rsp;

  logic                        pix_go;
  logic                        frame_done;
  logic                        none_bright;
  logic                        out_load;
  logic                        out_valid_r;
  logic [bsc_pkg::COORD_W-1:0] out_x_r;
  logic [bsc_pkg::COORD_W-1:0] out_y_r;
  logic                        out_none_r;
  logic [bsc_pkg::COORD_W-1:0] qx_r;
  logic [bsc_pkg::SUM_W-1:0]   hold_y_r;
  logic [bsc_pkg::TOT_W-1:0]   hold_tot_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= bsc_pkg::THR_RESET;
      fw_r  <= bsc_pkg::FW_RESET;
      fh_r  <= bsc_pkg::FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::REG_THRESHOLD:    thr_r <= cfg_wdata[bsc_pkg::PIX_W-1:0];
        bsc_pkg::REG_FRAME_WIDTH:  fw_r  <= cfg_wdata;
        bsc_pkg::REG_FRAME_HEIGHT: fh_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero acts as one, oversize saturates
  always_comb begin
    if (fw_r == '0) begin
      eff_w = EW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(fw_r);
    end
    if (fh_r == '0) begin
      eff_h = EH'(1);
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(fh_r);
    end
  end

  bsc_acc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_go    (pix_go),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .threshold (thr_r),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .stat      (acc_st)
  );

  // Hold off pixels during a division, and the last pixel of a frame while a result still waits
  assign in_tready   = (state_r == ST_IDLE) && !(acc_st.frame_end && out_valid_r);
  assign pix_go      = in_tvalid && in_tready;
  assign frame_done  = pix_go && acc_st.frame_end;
  assign none_bright = acc_st.total == '0;

  // Start column division at frame end, row division when the first one finishes
  always_comb begin
    div_req.start = (frame_done && !none_bright) || (state_r == ST_DIV_X && div_rsp.done);
    if (state_r == ST_IDLE) begin
      div_req.dividend = acc_st.sum_x;
      div_req.divisor  = acc_st.total;
    end else begin
      div_req.dividend = hold_y_r;
      div_req.divisor  = hold_tot_r;
    end
  end

  bsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_load = (frame_done && none_bright) || (state_r == ST_DIV_Y && div_rsp.done);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (frame_done && !none_bright) begin
            hold_y_r   <= acc_st.sum_y;
            hold_tot_r <= acc_st.total;
            state_r    <= ST_DIV_X;
          end
        end
        ST_DIV_X: begin
          if (div_rsp.done) begin
            qx_r    <= div_rsp.quotient[bsc_pkg::COORD_W-1:0];
            state_r <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          if (div_rsp.done) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        if (state_r == ST_IDLE) begin
          out_x_r    <= bsc_pkg::COORD_W'(eff_w >> 1);
          out_y_r    <= bsc_pkg::COORD_W'(eff_h >> 1);
          out_none_r <= 1'b1;
        end else begin
          out_x_r    <= qx_r;
          out_y_r    <= div_rsp.quotient[bsc_pkg::COORD_W-1:0];
          out_none_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_none_r;

  // Divider finishes only inside a division sequence
  ap_done_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_X || state_r == ST_DIV_Y))
    else $error("divider finished outside a division sequence");

  // A new result never overwrites one still waiting
  ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r)
    else $error("result written over an untaken result");

  // A started division keeps the divider busy on the next cycle
  ap_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> div_rsp.busy)
    else $error("divider did not start");

  // No pixel is taken while the divider runs
  ap_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> !in_tready)
    else $error("pixel accepted during division");

endmodule

// ===== sv/bsc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the column and row divisions.
module bsc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bsc_pkg::div_req_t req,
  output bsc_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(bsc_pkg::SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(bsc_pkg::SUM_W - 1);

  logic [bsc_pkg::SUM_W-1:0] quo_r, quo_nxt;
  logic [bsc_pkg::TOT_W-1:0] rem_r, rem_nxt;
  logic [bsc_pkg::TOT_W-1:0] dvs_r;
  logic [STEP_W-1:0]         step_r;
  logic                      busy_r;
  logic                      done_r;

  logic [bsc_pkg::TOT_W:0] shifted;
  logic [bsc_pkg::TOT_W:0] diff;
  logic                    take;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    shifted = {rem_r, quo_r[bsc_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    take    = !diff[bsc_pkg::TOT_W];
    rem_nxt = take ? diff[bsc_pkg::TOT_W-1:0] : shifted[bsc_pkg::TOT_W-1:0];
    quo_nxt = {quo_r[bsc_pkg::SUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== sv/bsc_acc.sv =====
// Raster position counters and bright pixel count and coordinate sums.
module bsc_acc #(
  parameter int MAX_WIDTH  = bsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pix_go,
  input  logic [bsc_pkg::PIX_W-1:0]        red,
  input  logic [bsc_pkg::PIX_W-1:0]        green,
  input  logic [bsc_pkg::PIX_W-1:0]        blue,
  input  logic [bsc_pkg::PIX_W-1:0]        threshold,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  eff_h,
  output bsc_pkg::acc_stat_t               stat
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]             col_r;
  logic [RW-1:0]             row_r;
  logic [bsc_pkg::TOT_W-1:0] tot_r;
  logic [bsc_pkg::SUM_W-1:0] sx_r;
  logic [bsc_pkg::SUM_W-1:0] sy_r;

  logic [9:0] lum_sum;
  logic [9:0] lum_lim;
  logic       bright;
  logic       col_more;
  logic       row_more;

  // Bright when floor(sum/3) > threshold, i.e. sum >= 3*threshold + 3
  always_comb begin
    lum_sum = 10'(red) + 10'(green) + 10'(blue);
    lum_lim = {1'b0, threshold, 1'b0} + 10'(threshold) + 10'd3;
    bright  = lum_sum >= lum_lim;
  end

  // Row and frame end tests against the current dimensions
  always_comb begin
    col_more = (32'(col_r) + 32'd1) < 32'(eff_w);
    row_more = (32'(row_r) + 32'd1) < 32'(eff_h);
  end

  // Totals that include the pixel now offered
  always_comb begin
    stat.frame_end = !col_more && !row_more;
    stat.total     = tot_r + bsc_pkg::TOT_W'(bright);
    stat.sum_x     = bright ? sx_r + bsc_pkg::SUM_W'(col_r) : sx_r;
    stat.sum_y     = bright ? sy_r + bsc_pkg::SUM_W'(row_r) : sy_r;
  end

  // Advance on each accepted pixel, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      tot_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
    end else if (pix_go) begin
      if (stat.frame_end) begin
        col_r <= '0;
        row_r <= '0;
        tot_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
      end else begin
        tot_r <= stat.total;
        sx_r  <= stat.sum_x;
        sy_r  <= stat.sum_y;
        if (col_more) begin
          col_r <= col_r + 1'b1;
        end else begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end
      end
    end
  end

endmodule
